### rtl/core/hsi_pkg.sv
package hsi_pkg;

  localparam int SLOT_COUNT_DEF  = 10;
  localparam int MAX_KEY_LEN_DEF = 99;

  localparam int KEY_W      = 8;
  localparam int SUM_W      = 15;
  localparam int SLOT_IDX_W = 4;
  localparam int OUTCOME_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam int STEP_W     = 2;
  // widest pre-reduction hash value (mid-square of a 15-bit sum, over 100)
  localparam int HASH_W     = 24;

  // floor(s / d) == (s * M) >> SH for every 15-bit s
  localparam logic [15:0] RCP10_M    = 16'd26215;
  localparam int          RCP10_SH   = 18;
  localparam logic [15:0] RCP100_M   = 16'd20972;
  localparam int          RCP100_SH  = 21;
  localparam logic [15:0] RCP1K_M    = 16'd33555;
  localparam int          RCP1K_SH   = 25;
  localparam logic [15:0] RCP10K_M   = 16'd26844;
  localparam int          RCP10K_SH  = 28;

  typedef enum logic [1:0] {
    HM_MID_SQUARE,
    HM_DIGIT_SUM,
    HM_TENS_DIGIT,
    HM_ROTATE4
  } hash_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HASH_MODE,
    CFG_PROBE_STEP
  } cfg_idx_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_HOME,
    OC_PROBED,
    OC_FAILED,
    OC_TOO_LONG
  } outcome_t;

  typedef struct packed {
    hash_mode_t        hash_mode;
    logic [STEP_W-1:0] probe_step;
  } cfg_t;

  // control bits that travel with a key through the pipeline
  typedef struct packed {
    logic vld;
    logic too_long;
  } tok_t;

  // floor(e*e/100) for the low two decimal digits of the sum
  typedef logic [6:0] sqd_tbl_t [128];

  function automatic sqd_tbl_t sqd_build();
    sqd_tbl_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = 7'((i * i) / 100);
    end
    return t;
  endfunction

  localparam sqd_tbl_t SQD100 = sqd_build();

endpackage

### rtl/core/hsi_chan_if.sv
interface hsi_in_if;
  import hsi_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_byte;
  logic             last_byte;

  modport source (output valid, output key_byte, output last_byte, input ready);
  modport sink   (input valid, input key_byte, input last_byte, output ready);
endinterface

interface hsi_out_if;
  import hsi_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [OUTCOME_W-1:0]  outcome;

  modport source (output valid, output slot_index, output outcome, input ready);
  modport sink   (input valid, input slot_index, input outcome, output ready);
endinterface

### rtl/core/hsi_accum.sv
module hsi_accum #(
  parameter int MAX_KEY_LEN = hsi_pkg::MAX_KEY_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       acc,
  input  logic [hsi_pkg::KEY_W-1:0]  key_byte,
  input  logic                       last_byte,
  output hsi_pkg::tok_t              tok,
  output logic [hsi_pkg::SUM_W-1:0]  tok_sum
);
  import hsi_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEY_LEN + 2);

  logic [SUM_W-1:0] sum_r, sum_nxt, sum_upd, tok_sum_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  tok_t             tok_r, tok_nxt;

  always_comb begin
    sum_upd = sum_r;
    cnt_upd = cnt_r;
    if (cnt_r < CNT_W'(MAX_KEY_LEN)) begin
      sum_upd = sum_r + SUM_W'(key_byte);
      cnt_upd = cnt_r + CNT_W'(1);
    end else begin
      // count parks one past the limit: marks the key as too long
      cnt_upd = CNT_W'(MAX_KEY_LEN + 1);
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (acc) begin
      if (last_byte) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_upd;
        cnt_nxt = cnt_upd;
      end
    end
    tok_nxt.vld      = acc & last_byte;
    tok_nxt.too_long = cnt_upd > CNT_W'(MAX_KEY_LEN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      tok_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      if (en) begin
        tok_r <= tok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_sum_r <= sum_upd;
    end
  end

  assign tok     = tok_r;
  assign tok_sum = tok_sum_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_KEY_LEN + 1))
    else $error("key byte count beyond its stop value");

endmodule

### rtl/core/hsi_hash.sv
module hsi_hash #(
  parameter int SLOT_COUNT = hsi_pkg::SLOT_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  hsi_pkg::hash_mode_t              hash_mode,
  input  hsi_pkg::tok_t                    tok_i,
  input  logic [hsi_pkg::SUM_W-1:0]        sum_i,
  output hsi_pkg::tok_t                    tok_o,
  output logic [$clog2(SLOT_COUNT)-1:0]    home_o
);
  import hsi_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int NW     = $clog2(SLOT_COUNT + 1);
  localparam int P_W    = SUM_W + 16;
  // residues of powers of two, used to fold wide values down, and a reciprocal of SLOT_COUNT
  localparam int K12    = 4096 % SLOT_COUNT;
  localparam int R28    = (1 << 28) % SLOT_COUNT;
  localparam int MN     = 65536 / SLOT_COUNT;
  localparam int F1_W   = 12 + SLOT_W + 1;
  localparam int H2_W   = F1_W - 12;
  localparam int V_W    = ((H2_W + SLOT_W) > 12 ? (H2_W + SLOT_W) : 12) + 1;
  localparam int M_W    = V_W + 16;
  localparam int QN_W   = V_W + NW;

  // stage A: decimal quotients of the sum
  tok_t             a_tok_r;
  logic [SUM_W-1:0] a_s_r;
  logic [11:0]      a_q1_r;
  logic [8:0]       a_q2_r;
  logic [5:0]       a_q3_r;
  logic [1:0]       a_q4_r;
  logic [P_W-1:0]   p1, p2, p3, p4;

  always_comb begin
    p1 = P_W'(sum_i) * P_W'(RCP10_M);
    p2 = P_W'(sum_i) * P_W'(RCP100_M);
    p3 = P_W'(sum_i) * P_W'(RCP1K_M);
    p4 = P_W'(sum_i) * P_W'(RCP10K_M);
  end

  // stage B: mid-square partial terms, other modes finish here
  tok_t             b_tok_r;
  logic [16:0]      b_c2_r;
  logic [15:0]      b_ce2_r;
  logic [6:0]       b_t_r;
  logic [SUM_W-1:0] b_wo_r;
  logic [SUM_W-1:0] c100, e_full, qsum9, rot, wo;
  logic [6:0]       e;
  logic [17:0]      c2;
  logic [14:0]      ce;
  logic [11:0]      qsum;

  always_comb begin
    c100   = SUM_W'(a_q2_r) * SUM_W'(100);
    e_full = a_s_r - c100;
    e      = e_full[6:0];
    c2     = 18'(a_q2_r) * 18'(a_q2_r);
    ce     = 15'(a_q2_r) * 15'(e);
    qsum   = 12'(a_q1_r) + 12'(a_q2_r) + 12'(a_q3_r) + 12'(a_q4_r);
    // digit sum = s - 9 * sum of s / 10^k
    qsum9  = SUM_W'(qsum) * SUM_W'(9);
    rot    = SUM_W'(a_s_r[SUM_W-1:4]) + SUM_W'(a_s_r[3:0]) * SUM_W'(R28);
    case (hash_mode)
      HM_DIGIT_SUM:  wo = a_s_r - qsum9;
      HM_TENS_DIGIT: wo = SUM_W'(a_q1_r);
      HM_ROTATE4:    wo = rot;
      default:       wo = '0;
    endcase
  end

  // stage C: s*s/100 = 100*c*c + 2*c*e + e*e/100 with s = 100*c + e
  tok_t              c_tok_r;
  logic [HASH_W-1:0] c_w_r, w;

  always_comb begin
    if (hash_mode == HM_MID_SQUARE) begin
      w = HASH_W'(b_c2_r) * HASH_W'(100) + HASH_W'(b_ce2_r) + HASH_W'(b_t_r);
    end else begin
      w = HASH_W'(b_wo_r);
    end
  end

  // stages D, E: two folds at 12 bits, residue preserved
  tok_t            d_tok_r, e_tok_r;
  logic [F1_W-1:0] d_w_r, fold1;
  logic [V_W-1:0]  e_v_r, fold2;

  always_comb begin
    fold1 = F1_W'(c_w_r[HASH_W-1:12]) * F1_W'(K12) + F1_W'(c_w_r[11:0]);
    fold2 = V_W'(d_w_r[F1_W-1:12]) * V_W'(K12) + V_W'(d_w_r[11:0]);
  end

  // stage F: quotient estimate, low by at most one
  tok_t           f_tok_r;
  logic [V_W-1:0] f_q_r, f_v_r;
  logic [M_W-1:0] qprod;

  always_comb begin
    qprod = M_W'(e_v_r) * M_W'(MN);
  end

  // stage G: remainder with one correction
  tok_t              g_tok_r;
  logic [SLOT_W-1:0] g_home_r, home;
  logic [QN_W-1:0]   qn, diff;
  logic [SLOT_W:0]   rem;

  always_comb begin
    qn   = QN_W'(f_q_r) * QN_W'(SLOT_COUNT);
    diff = QN_W'(f_v_r) - qn;
    rem  = diff[SLOT_W:0];
    if (rem >= (SLOT_W+1)'(SLOT_COUNT)) begin
      home = SLOT_W'(rem - (SLOT_W+1)'(SLOT_COUNT));
    end else begin
      home = SLOT_W'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tok_r <= '0;
      b_tok_r <= '0;
      c_tok_r <= '0;
      d_tok_r <= '0;
      e_tok_r <= '0;
      f_tok_r <= '0;
      g_tok_r <= '0;
    end else if (en) begin
      a_tok_r <= tok_i;
      b_tok_r <= a_tok_r;
      c_tok_r <= b_tok_r;
      d_tok_r <= c_tok_r;
      e_tok_r <= d_tok_r;
      f_tok_r <= e_tok_r;
      g_tok_r <= f_tok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_s_r    <= sum_i;
      a_q1_r   <= p1[RCP10_SH +: 12];
      a_q2_r   <= p2[RCP100_SH +: 9];
      a_q3_r   <= p3[RCP1K_SH +: 6];
      a_q4_r   <= p4[RCP10K_SH +: 2];
      b_c2_r   <= c2[16:0];
      b_ce2_r  <= {ce, 1'b0};
      b_t_r    <= SQD100[e];
      b_wo_r   <= wo;
      c_w_r    <= w;
      d_w_r    <= fold1;
      e_v_r    <= fold2;
      f_q_r    <= qprod[16 +: V_W];
      f_v_r    <= e_v_r;
      g_home_r <= home;
    end
  end

  assign tok_o  = g_tok_r;
  assign home_o = g_home_r;

  a_home_range: assert property (@(posedge clk) disable iff (!rst_n)
    g_tok_r.vld |-> ({1'b0, g_home_r} < (SLOT_W+1)'(SLOT_COUNT)))
    else $error("home slot outside the table");

endmodule

### rtl/core/hsi_table.sv
module hsi_table #(
  parameter int SLOT_COUNT = hsi_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  hsi_pkg::tok_t                   tok_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]   home_i,
  input  logic [hsi_pkg::STEP_W-1:0]      probe_step,
  output logic                            out_vld,
  output logic [$clog2(SLOT_COUNT)-1:0]   out_slot,
  output hsi_pkg::outcome_t               out_outcome
);
  import hsi_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int A_W    = SLOT_W + 2;

  logic [SLOT_COUNT-1:0] used_r, used_nxt;
  logic                  out_vld_r;
  logic [SLOT_W-1:0]     slot_r, slot_nxt, alt;
  outcome_t              outcome_r, outcome_nxt;
  logic [A_W-1:0]        alt_sum;

  // probe slot, wrapped; step may exceed a tiny table once
  always_comb begin
    alt_sum = A_W'(home_i) + A_W'(probe_step);
    if (alt_sum >= A_W'(2 * SLOT_COUNT)) begin
      alt = SLOT_W'(alt_sum - A_W'(2 * SLOT_COUNT));
    end else if (alt_sum >= A_W'(SLOT_COUNT)) begin
      alt = SLOT_W'(alt_sum - A_W'(SLOT_COUNT));
    end else begin
      alt = SLOT_W'(alt_sum);
    end
  end

  always_comb begin
    used_nxt    = used_r;
    slot_nxt    = home_i;
    outcome_nxt = OC_FAILED;
    if (tok_i.too_long) begin
      slot_nxt    = '0;
      outcome_nxt = OC_TOO_LONG;
    end else if (!used_r[home_i]) begin
      used_nxt[home_i] = 1'b1;
      outcome_nxt      = OC_HOME;
    end else if (!used_r[alt]) begin
      used_nxt[alt] = 1'b1;
      slot_nxt      = alt;
      outcome_nxt   = OC_PROBED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= tok_i.vld;
      if (tok_i.vld) begin
        used_r <= used_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot_r    <= slot_nxt;
      outcome_r <= outcome_nxt;
    end
  end

  assign out_vld     = out_vld_r;
  assign out_slot    = slot_r;
  assign out_outcome = outcome_r;

  a_used_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r & $past(used_r)) == $past(used_r))
    else $error("occupied slot was freed");

  a_one_insert: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r ^ $past(used_r)) <= 1)
    else $error("more than one slot taken by one key");

  a_placed_used: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (outcome_r == OC_HOME || outcome_r == OC_PROBED))
      |-> used_r[slot_r])
    else $error("reported slot not marked used");

endmodule

### rtl/core/hash_slot_insert_top.sv
// Path: accumulator register, hash stages A to G, table register, then the result word.
// Throughput: one key byte per cycle while the output is not stalled; one result per key.
// The whole pipeline stalls only while a result word waits on the output.
// Reset (synchronous): table empty, byte sum and count cleared, hash_mode 0, probe_step 1.
module hash_slot_insert_top #(
  parameter int SLOT_COUNT  = hsi_pkg::SLOT_COUNT_DEF,
  parameter int MAX_KEY_LEN = hsi_pkg::MAX_KEY_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hsi_in_if.sink                           in_chan,
  hsi_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [hsi_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [hsi_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import hsi_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);

  cfg_t              cfg_r;
  logic              en, acc;
  tok_t              acc_tok, hash_tok;
  logic [SUM_W-1:0]  acc_sum;
  logic [SLOT_W-1:0] home, out_slot;
  logic              out_vld;
  outcome_t          out_outcome;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hash_mode  <= HM_MID_SQUARE;
      cfg_r.probe_step <= STEP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_HASH_MODE:  cfg_r.hash_mode  <= hash_mode_t'(cfg_wdata);
        CFG_PROBE_STEP: cfg_r.probe_step <= STEP_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output word is empty or being taken
  assign en  = !out_vld || out_chan.ready;
  assign acc = in_chan.valid && en;
  assign in_chan.ready = en;

  hsi_accum #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .acc       (acc),
    .key_byte  (in_chan.key_byte),
    .last_byte (in_chan.last_byte),
    .tok       (acc_tok),
    .tok_sum   (acc_sum)
  );

  hsi_hash #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .hash_mode (cfg_r.hash_mode),
    .tok_i     (acc_tok),
    .sum_i     (acc_sum),
    .tok_o     (hash_tok),
    .home_o    (home)
  );

  hsi_table #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .tok_i       (hash_tok),
    .home_i      (home),
    .probe_step  (cfg_r.probe_step),
    .out_vld     (out_vld),
    .out_slot    (out_slot),
    .out_outcome (out_outcome)
  );

  assign out_chan.valid      = out_vld;
  assign out_chan.slot_index = SLOT_IDX_W'(out_slot);
  assign out_chan.outcome    = out_outcome;

endmodule
